/* hw/rtl/grd_pkg.sv */
// ----------------------------------------------------------------------------
// grd_pkg
// Shared types and constants of the greedy rectangle decomposer.
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int unsigned SIDE      = 64;
  localparam int unsigned COORD_W   = $clog2(SIDE);
  localparam int unsigned DIM_W     = COORD_W + 1;
  localparam int unsigned POS_W     = 2 * COORD_W + 1;
  localparam int unsigned CELL_AW   = 2 * COORD_W;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_NEXT    = 2'd2
  } cmd_t;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ORG_RD,
    ST_ORG_CHK,
    ST_RIGHT_RD,
    ST_RIGHT_CHK,
    ST_DOWN_RD,
    ST_DOWN_CHK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/greedy_rectangle_decomposer_unit.sv */
// ----------------------------------------------------------------------------
// greedy_rectangle_decomposer_unit
// Splits a stored height grid greedily into rectangles of equal height.
// ----------------------------------------------------------------------------
// Load and unknown commands are handled in the idle state; a restart clears
// the covered map one map row per cycle, and the same pass runs after reset.
// A next command scans rows for an uncovered cell, reads the origin, checks
// cells on the rightward run and then downward, and marks the covered rows;
// the rightward run stops at the grid edge, at a covered cell or at another
// height, and the result is presented once the output register is free.
module greedy_rectangle_decomposer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cell_x, cell_y, cell_height, zero fill
  input  logic [grd_pkg::IN_DATA_W-1:0]    s_tdata,
  // command
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // origin_x, origin_y, span_x, span_y, level, zero fill
  output logic [grd_pkg::OUT_DATA_W-1:0]   m_tdata,
  // none_left
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [grd_pkg::DIM_W-1:0]        cfg_data
);

  localparam int unsigned CW = grd_pkg::COORD_W;
  localparam int unsigned DW = grd_pkg::DIM_W;
  localparam int unsigned PW = grd_pkg::POS_W;
  localparam int unsigned LW = grd_pkg::LEVEL_W;
  localparam int unsigned SIDE = grd_pkg::SIDE;
  localparam int unsigned CELLS = SIDE * SIDE;

  grd_pkg::state_t state, state_next;

  logic [DW-1:0] grid_cols, grid_rows;
  logic [DW-1:0] w_use, h_use;

  logic [LW-1:0]   height_mem [CELLS];
  logic [SIDE-1:0] visit_mem  [SIDE];

  logic                        h_we;
  logic [grd_pkg::CELL_AW-1:0] h_waddr, h_raddr;
  logic [LW-1:0]               h_rdata;
  logic                        v_we;
  logic [CW-1:0]               v_waddr, v_raddr;
  logic [SIDE-1:0]             v_wdata, v_rdata;

  logic [PW-1:0]   pos;
  logic [CW-1:0]   ox, oy, col, clr_cnt;
  logic [DW-1:0]   right, row, mrow;
  logic [LW-1:0]   lvl;
  logic [SIDE-1:0] vrow;
  logic            none;

  logic            in_fire, emit_fire;
  grd_pkg::cmd_t   cmd;
  logic [SIDE-1:0] cand, run_mask;
  logic [CW-1:0]   cand_idx;
  logic            cand_any;

  assign w_use = (grid_cols > DW'(SIDE)) ? DW'(SIDE) : grid_cols;
  assign h_use = (grid_rows > DW'(SIDE)) ? DW'(SIDE) : grid_rows;

  assign cmd       = grd_pkg::cmd_t'(s_tuser);
  assign in_fire   = s_tvalid && s_tready;
  assign emit_fire = (state == grd_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= DW'(SIDE);
      grid_rows <= DW'(SIDE);
    end else if (cfg_we) begin
      if (cfg_index == grd_pkg::CFG_COLS) begin
        grid_cols <= cfg_data;
      end else begin
        grid_rows <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      height_mem[h_waddr] <= s_tdata[19:12];
    end
    h_rdata <= height_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      visit_mem[v_waddr] <= v_wdata;
    end
    v_rdata <= visit_mem[v_raddr];
  end

  always_comb begin
    cand     = '0;
    run_mask = '0;
    for (int i = 0; i < SIDE; i++) begin
      cand[i]     = !v_rdata[i] && (DW'(i) >= {1'b0, pos[CW-1:0]}) && (DW'(i) < w_use);
      run_mask[i] = (DW'(i) >= {1'b0, ox}) && (DW'(i) < right);
    end
  end

  always_comb begin
    cand_idx = '0;
    cand_any = |cand;
    for (int i = SIDE - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_idx = CW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      grd_pkg::ST_CLEAR: begin
        if (clr_cnt == CW'(SIDE - 1)) begin
          state_next = grd_pkg::ST_IDLE;
        end
      end
      grd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            grd_pkg::CMD_RESTART: state_next = grd_pkg::ST_CLEAR;
            grd_pkg::CMD_NEXT:    state_next = grd_pkg::ST_SCAN_RD;
            default:              state_next = grd_pkg::ST_IDLE;
          endcase
        end
      end
      grd_pkg::ST_SCAN_RD: begin
        if (pos[PW-1:CW] >= h_use) begin
          state_next = grd_pkg::ST_EMIT;
        end else begin
          state_next = grd_pkg::ST_SCAN_CHK;
        end
      end
      grd_pkg::ST_SCAN_CHK: begin
        state_next = cand_any ? grd_pkg::ST_ORG_RD : grd_pkg::ST_SCAN_RD;
      end
      grd_pkg::ST_ORG_RD:  state_next = grd_pkg::ST_ORG_CHK;
      grd_pkg::ST_ORG_CHK: state_next = grd_pkg::ST_RIGHT_RD;
      grd_pkg::ST_RIGHT_RD: begin
        if (right >= w_use || vrow[right[CW-1:0]]) begin
          state_next = grd_pkg::ST_DOWN_RD;
        end else begin
          state_next = grd_pkg::ST_RIGHT_CHK;
        end
      end
      grd_pkg::ST_RIGHT_CHK: begin
        state_next = (h_rdata == lvl) ? grd_pkg::ST_RIGHT_RD : grd_pkg::ST_DOWN_RD;
      end
      grd_pkg::ST_DOWN_RD: begin
        if (row >= h_use) begin
          state_next = grd_pkg::ST_MARK_RD;
        end else begin
          state_next = grd_pkg::ST_DOWN_CHK;
        end
      end
      grd_pkg::ST_DOWN_CHK: begin
        state_next = (h_rdata != lvl) ? grd_pkg::ST_MARK_RD : grd_pkg::ST_DOWN_RD;
      end
      grd_pkg::ST_MARK_RD: state_next = grd_pkg::ST_MARK_WR;
      grd_pkg::ST_MARK_WR: begin
        state_next = (mrow + DW'(1) == row) ? grd_pkg::ST_EMIT : grd_pkg::ST_MARK_RD;
      end
      grd_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = grd_pkg::ST_IDLE;
        end
      end
      default: state_next = grd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    h_we     = 1'b0;
    h_waddr  = {s_tdata[11:6], s_tdata[5:0]};
    h_raddr  = {oy, ox};
    v_we     = 1'b0;
    v_waddr  = clr_cnt;
    v_wdata  = '0;
    v_raddr  = pos[2*CW-1:CW];
    unique case (state)
      grd_pkg::ST_CLEAR: begin
        v_we = 1'b1;
      end
      grd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        h_we     = in_fire && (cmd == grd_pkg::CMD_LOAD);
      end
      grd_pkg::ST_RIGHT_RD: h_raddr = {oy, right[CW-1:0]};
      grd_pkg::ST_DOWN_RD:  h_raddr = {row[CW-1:0], col};
      grd_pkg::ST_MARK_RD:  v_raddr = mrow[CW-1:0];
      grd_pkg::ST_MARK_WR: begin
        v_we    = 1'b1;
        v_waddr = mrow[CW-1:0];
        v_wdata = v_rdata | run_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= grd_pkg::ST_CLEAR;
      clr_cnt <= '0;
      pos     <= '0;
      none    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        grd_pkg::ST_CLEAR: clr_cnt <= clr_cnt + CW'(1);
        grd_pkg::ST_IDLE: begin
          if (in_fire && cmd == grd_pkg::CMD_RESTART) begin
            pos     <= '0;
            clr_cnt <= '0;
          end
          none <= 1'b0;
        end
        grd_pkg::ST_SCAN_RD: begin
          if (pos[PW-1:CW] >= h_use) begin
            pos  <= PW'(CELLS);
            none <= 1'b1;
          end
        end
        grd_pkg::ST_SCAN_CHK: begin
          if (cand_any) begin
            pos <= {pos[PW-1:CW], cand_idx};
            ox  <= cand_idx;
            oy  <= pos[2*CW-1:CW];
          end else begin
            pos <= {pos[PW-1:CW] + DW'(1), {CW{1'b0}}};
          end
          vrow <= v_rdata;
        end
        grd_pkg::ST_ORG_CHK: begin
          lvl   <= h_rdata;
          right <= {1'b0, ox} + DW'(1);
          row   <= {1'b0, oy} + DW'(1);
          col   <= ox;
        end
        grd_pkg::ST_RIGHT_CHK: begin
          if (h_rdata == lvl) begin
            right <= right + DW'(1);
          end
        end
        grd_pkg::ST_DOWN_CHK: begin
          if (h_rdata == lvl) begin
            if ({1'b0, col} + DW'(1) == right) begin
              row <= row + DW'(1);
              col <= ox;
            end else begin
              col <= col + CW'(1);
            end
          end
        end
        grd_pkg::ST_MARK_WR: begin
          mrow <= mrow + DW'(1);
          if (mrow + DW'(1) == row) begin
            pos <= pos + PW'(1);
          end
        end
        default: begin
        end
      endcase
      if (state == grd_pkg::ST_ORG_CHK) begin
        mrow <= {1'b0, oy};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tuser <= none;
      if (none) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {6'd0, lvl, row - {1'b0, oy}, right - {1'b0, ox}, oy, ox};
      end
    end
  end

endmodule
